// ----- src/stl_pkg.sv -----
// ============================================================================
// stl_pkg: shared types, constants and sine table function
// Frame and multiplier structs, register codes, reset values and the
// quarter-wave sine generator evaluated at elaboration.
// ============================================================================
package stl_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_PHASE_BITS      = 32;

    localparam int LFO_BITS     = 18;   // raw LFO and LFO minus smoother, signed
    localparam int SMOOTH_BITS  = 17;   // smoother state, signed, +/-32768
    localparam int COEF_BITS    = 16;   // Q1.15 unsigned operands, 0..32768
    localparam int MUL_A_BITS   = (SAMPLE_BITS > LFO_BITS) ? SAMPLE_BITS : LFO_BITS;
    localparam int MUL_P_BITS   = MUL_A_BITS + 2;    // product after asr 15
    localparam int MUL_CNT_BITS = $clog2(COEF_BITS + 1);

    localparam int NOISE_STEPS     = 16;
    localparam int NOISE_CNT_BITS  = $clog2(NOISE_STEPS + 1);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [COEF_BITS-1:0] Q_ONE       = 16'd32768;
    localparam logic [LFO_BITS-1:0]  LFO_ONE     = 18'd32768;
    localparam logic [LFO_BITS-1:0]  LFO_NEG_ONE = 18'h38000;    // -32768
    localparam logic [LFO_BITS-1:0]  TRI_PEAK    = 18'd65536;
    localparam logic [31:0]          TRI_FALL_END = 32'hC000_0000;
    localparam logic [31:0]          PULSE_LIMIT = 32'd858993459;
    localparam logic [31:0]          LFSR_MASK   = 32'h8020_0003;
    localparam logic [31:0]          NOISE_SEED  = 32'hACE1_ACE1;

    localparam int SMOOTH_MIN = -32768;
    localparam int SMOOTH_MAX = 32768;

    localparam logic [31:0]          RST_PHASE_INC = 32'd402653;
    localparam logic [COEF_BITS-1:0] RST_DEPTH     = 16'd24576;
    localparam logic [2:0]           RST_SHAPE     = 3'd0;
    localparam logic [COEF_BITS-1:0] RST_COEFF     = 16'd23036;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_INC = 3'd0,
        CFG_DEPTH     = 3'd1,
        CFG_SHAPE     = 3'd2,
        CFG_SMOOTH    = 3'd3,
        CFG_PAN_SYNC  = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_NOISE    = 3'd3,
        WAVE_SQUARE   = 3'd4,
        WAVE_PULSE    = 3'd5
    } t_wave_shape;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_frame;

    typedef struct packed {
        logic                         start;
        logic signed [MUL_A_BITS-1:0] mcand;
        logic [COEF_BITS-1:0]         mplier;
    } t_mul_req;

    typedef struct packed {
        logic                         busy;
        logic                         done;
        logic signed [MUL_P_BITS-1:0] prod;     // product, asr 15
    } t_mul_rsp;

    typedef struct packed {
        logic                       done;
        logic signed [LFO_BITS-1:0] draw;
    } t_noise_rsp;

    // Quarter-wave sine magnitude, 32768 * sin(pi/2 * k / 2^qbits), from a
    // Q30 Taylor series up to x^11. Only called with constant arguments.
    function automatic logic [COEF_BITS-1:0] sine_quarter(input int unsigned k,
                                                          input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned s;
        x  = (64'(k) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        r  = Q30_ONE;
        r  = Q30_ONE - ((x2 * r) >> 30) / 110;
        r  = Q30_ONE - ((x2 * r) >> 30) / 72;
        r  = Q30_ONE - ((x2 * r) >> 30) / 42;
        r  = Q30_ONE - ((x2 * r) >> 30) / 20;
        r  = Q30_ONE - ((x2 * r) >> 30) / 6;
        s  = (x * r) >> 30;
        s  = (s * 64'd32768 + (Q30_ONE >> 1)) >> 30;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return COEF_BITS'(s);
    endfunction

endpackage

// ----- src/stereo_tremolo_lfo.sv -----
// ============================================================================
// stereo_tremolo_lfo: stereo tremolo with LFO, smoother and gain stage
// Amplitude-modulates one stereo frame per transaction.
// ============================================================================
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one stereo frame
//   (i_in_data). Output channel: o_out_valid / i_out_stall carry the
//   modulated frame (o_out_data). One output transaction per input.
//   Configuration: pulse i_cfg_we with i_cfg_index / i_cfg_data while the
//   block is idle; depth and smoothing above 32768 are clamped on write.
// Sequence:
//   All products go through one bit-serial multiplier. A frame runs the
//   wave, smoother, gain, left and right modulation steps in turn before
//   o_out_valid; pan sync repeats the wave, smoother and gain steps for the
//   right LFO path, and each noise draw waits for its LFSR shifting. The
//   next frame is accepted in the cycle after the result enters the output
//   register, so a new frame is not taken before the last one is through.
// Reset (i_rst_n low, synchronous): registers return to defaults, phase
//   and smoothers clear, the noise LFSR reloads its seed, no output valid.
// Stall: a stalled result holds in the output register; the next frame is
//   still processed, and it waits in the datapath until the register frees.
// ============================================================================
module stereo_tremolo_lfo import stl_pkg::*; #(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_frame                 i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_frame                o_out_data
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_WAVE      = 8'b0000_0010,
        S_WAVE_WAIT = 8'b0000_0100,
        S_SMOOTH    = 8'b0000_1000,
        S_GAIN      = 8'b0001_0000,
        S_MOD_L     = 8'b0010_0000,
        S_MOD_R     = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [31:0]          r_phase_inc;
    logic [COEF_BITS-1:0] r_depth;
    logic [2:0]           r_shape;
    logic [COEF_BITS-1:0] r_coeff;
    logic                 r_pan;
    logic [COEF_BITS-1:0] cfg_sat;

    // LFO and datapath state
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS-1:0]          r_phase_sel;
    logic                           r_chan_r;
    logic signed [SMOOTH_BITS-1:0]  r_smooth_l;
    logic signed [SMOOTH_BITS-1:0]  r_smooth_r;
    logic [COEF_BITS-1:0]           r_gain_l;
    logic [COEF_BITS-1:0]           r_gain_r;
    logic signed [SAMPLE_BITS-1:0]  r_left_in;
    logic signed [SAMPLE_BITS-1:0]  r_right_in;
    logic signed [SAMPLE_BITS-1:0]  r_left_res;
    t_out_frame                     r_out;
    logic                           r_out_valid;

    logic                           in_accept;
    logic                           out_load;
    logic [31:0]                    p;
    logic [16:0]                    tri_t;
    logic signed [LFO_BITS-1:0]     sine_val;
    logic signed [LFO_BITS-1:0]     raw;
    logic signed [SMOOTH_BITS-1:0]  cur_smooth;
    logic signed [LFO_BITS-1:0]     lfo_diff;
    logic signed [SMOOTH_BITS-1:0]  n_smooth;
    logic [SMOOTH_BITS-1:0]         u_sum;
    logic [COEF_BITS-1:0]           u_val;
    logic [COEF_BITS-1:0]           gain_now;
    logic                           wave_ready;
    logic                           noise_start;
    t_noise_rsp                     noise_rsp;
    t_mul_req                       mul_req;
    t_mul_rsp                       mul_rsp;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    // load the output register when it is empty or being drained this cycle
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    // clamp Q1.15 values above full scale
    assign cfg_sat = (i_cfg_data[COEF_BITS-1:0] > Q_ONE) ? Q_ONE
                                                        : i_cfg_data[COEF_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= RST_PHASE_INC;
            r_depth     <= RST_DEPTH;
            r_shape     <= RST_SHAPE;
            r_coeff     <= RST_COEFF;
            r_pan       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data;
                CFG_DEPTH:     r_depth     <= cfg_sat;
                CFG_SHAPE:     r_shape     <= i_cfg_data[2:0];
                CFG_SMOOTH:    r_coeff     <= cfg_sat;
                CFG_PAN_SYNC:  r_pan       <= i_cfg_data[0];
                default: ;     // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Waveform generation from the selected phase, scaled to 32 bits
    // ---------------------------------------------------------------------
    assign p     = 32'(r_phase_sel) << (32 - PHASE_BITS);
    assign tri_t = p[31:15];

    stl_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_index (p[31 -: SINE_TABLE_BITS]),
        .o_value (sine_val)
    );

    stl_noise_lfsr u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (noise_start),
        .o_rsp   (noise_rsp)
    );

    always_comb begin
        unique case (r_shape)
            WAVE_SINE:     raw = sine_val;
            WAVE_TRIANGLE: begin
                if (p[31:30] == 2'b00) begin
                    raw = $signed({1'b0, tri_t});
                end else if (p < TRI_FALL_END) begin
                    raw = $signed(TRI_PEAK - {1'b0, tri_t});
                end else begin
                    // t - 131072 within 18 bits
                    raw = $signed({1'b1, tri_t});
                end
            end
            WAVE_SAW:      raw = $signed({2'b00, p[31:16]} - LFO_ONE);
            WAVE_NOISE:    raw = noise_rsp.draw;
            WAVE_SQUARE:   raw = p[31] ? $signed(LFO_NEG_ONE) : $signed(LFO_ONE);
            WAVE_PULSE:    raw = (p <= PULSE_LIMIT) ? $signed(LFO_ONE)
                                                    : $signed(LFO_NEG_ONE);
            default:       raw = '0;
        endcase
    end

    // noise waits for its LFSR shifts; the sine table's read register is covered by S_WAVE
    assign wave_ready = (r_shape != WAVE_NOISE) || noise_rsp.done;

    // ---------------------------------------------------------------------
    // Smoother and gain arithmetic around the shared multiplier
    // ---------------------------------------------------------------------
    assign cur_smooth = r_chan_r ? r_smooth_r : r_smooth_l;
    assign lfo_diff   = raw - LFO_BITS'(cur_smooth);
    assign n_smooth   = cur_smooth + $signed(mul_rsp.prod[SMOOTH_BITS-1:0]);
    assign u_sum      = n_smooth + SMOOTH_BITS'(Q_ONE);
    assign u_val      = u_sum[SMOOTH_BITS-1:1];
    assign gain_now   = Q_ONE - mul_rsp.prod[COEF_BITS-1:0];

    stl_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        noise_start    = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.mcand  = MUL_A_BITS'(lfo_diff);
        mul_req.mplier = r_coeff;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_WAVE;
                end
            end
            S_WAVE: begin
                noise_start = (r_shape == WAVE_NOISE);
                n_state     = S_WAVE_WAIT;
            end
            S_WAVE_WAIT: begin
                // smoother step: (raw - s) * coeff
                if (wave_ready) begin
                    mul_req.start = 1'b1;
                    n_state       = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                // depth step: ((s + 1) / 2) * depth
                if (mul_rsp.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = $signed(MUL_A_BITS'(u_val));
                    mul_req.mplier = r_depth;
                    n_state        = S_GAIN;
                end
            end
            S_GAIN: begin
                if (mul_rsp.done) begin
                    if (!r_chan_r && r_pan) begin
                        n_state = S_WAVE;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = MUL_A_BITS'(r_left_in);
                        mul_req.mplier = r_chan_r ? r_gain_l : gain_now;
                        n_state        = S_MOD_L;
                    end
                end
            end
            S_MOD_L: begin
                if (mul_rsp.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MUL_A_BITS'(r_right_in);
                    mul_req.mplier = r_pan ? r_gain_r : r_gain_l;
                    n_state        = S_MOD_R;
                end
            end
            S_MOD_R: begin
                if (mul_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and LFO state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_chan_r    <= 1'b0;
            r_smooth_l  <= '0;
            r_smooth_r  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_chan_r <= 1'b0;
            end
            if (r_state == S_SMOOTH && mul_rsp.done) begin
                if (r_chan_r) begin
                    r_smooth_r <= n_smooth;
                end else begin
                    r_smooth_l <= n_smooth;
                end
            end
            if (r_state == S_GAIN && mul_rsp.done && !r_chan_r && r_pan) begin
                r_chan_r <= 1'b1;
            end
            // advance the phase once per frame
            if (out_load) begin
                r_phase <= r_phase + r_phase_inc[PHASE_BITS-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_left_in   <= i_in_data.left_in;
            r_right_in  <= i_in_data.right_in;
            r_phase_sel <= r_phase;
        end
        if (r_state == S_GAIN && mul_rsp.done) begin
            if (r_chan_r) begin
                r_gain_r <= gain_now;
            end else begin
                r_gain_l <= gain_now;
            end
            // right channel reads the phase half an LFO period ahead
            if (!r_chan_r && r_pan) begin
                r_phase_sel <= {~r_phase_sel[PHASE_BITS-1], r_phase_sel[PHASE_BITS-2:0]};
            end
        end
        if (r_state == S_MOD_L && mul_rsp.done) begin
            r_left_res <= mul_rsp.prod[SAMPLE_BITS-1:0];
        end
        if (out_load) begin
            r_out.left_out  <= r_left_res;
            r_out.right_out <= mul_rsp.prod[SAMPLE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid raised outside the output state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction accepted while a frame is in progress");

    a_smooth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_smooth_l >= SMOOTH_MIN) && (r_smooth_l <= SMOOTH_MAX) &&
        (r_smooth_r >= SMOOTH_MIN) && (r_smooth_r <= SMOOTH_MAX))
        else $error("smoother state outside full scale");

endmodule

// ----- src/stl_sine_rom.sv -----
// ============================================================================
// stl_sine_rom: quarter-wave sine table with registered read
// Folds the full-cycle index onto a quarter table and restores the sign.
// ============================================================================
module stl_sine_rom import stl_pkg::*; #(
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic                       i_clk,
    input  logic [SINE_TABLE_BITS-1:0] i_index,
    output logic signed [LFO_BITS-1:0] o_value
);

    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QSIZE = 1 << QBITS;

    logic [COEF_BITS-1:0] rom [QSIZE+1];
    logic [1:0]           quad;
    logic [QBITS:0]       k_fwd;
    logic [QBITS:0]       k;
    logic [COEF_BITS-1:0] r_mag;
    logic                 r_neg;

    for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
        assign rom[g] = sine_quarter(g, QBITS);
    end

    assign quad  = i_index[SINE_TABLE_BITS-1 -: 2];
    assign k_fwd = {1'b0, i_index[QBITS-1:0]};
    // odd quadrants run the table backward
    assign k     = quad[0] ? ((QBITS+1)'(QSIZE) - k_fwd) : k_fwd;

    always_ff @(posedge i_clk) begin
        r_mag <= rom[k];
        r_neg <= quad[1];
    end

    assign o_value = r_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});

endmodule

// ----- src/stl_noise_lfsr.sv -----
// ============================================================================
// stl_noise_lfsr: noise source for the LFO
// Galois LFSR, one shift per cycle, sixteen shifts per draw.
// ============================================================================
module stl_noise_lfsr import stl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output t_noise_rsp o_rsp
);

    logic [31:0]               r_lfsr;
    logic [31:0]               n_lfsr;
    logic [NOISE_CNT_BITS-1:0] r_cnt;
    logic                      r_done;

    assign n_lfsr = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= NOISE_SEED;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= NOISE_CNT_BITS'(NOISE_STEPS);
            end else if (r_cnt != '0) begin
                r_lfsr <= n_lfsr;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == NOISE_CNT_BITS'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.draw = $signed({2'b00, r_lfsr[31:16]} - LFO_ONE);

endmodule

// ----- src/stl_serial_mul.sv -----
// ============================================================================
// stl_serial_mul: bit-serial shift-and-add multiplier
// Signed multiplicand times unsigned Q1.15 multiplier, one multiplier bit
// per cycle; the result is the product shifted right by 15.
// ============================================================================
module stl_serial_mul import stl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic signed [MUL_A_BITS-1:0] r_mcand;
    logic signed [MUL_A_BITS:0]   r_hi;
    logic signed [MUL_A_BITS:0]   n_hi;
    logic [COEF_BITS-1:0]         r_lo;
    logic [COEF_BITS-1:0]         n_lo;
    logic [MUL_A_BITS:0]          addend;
    logic [MUL_A_BITS:0]          sum;
    logic [MUL_CNT_BITS-1:0]      r_cnt;
    logic                         r_done;

    assign addend = r_lo[0] ? {r_mcand[MUL_A_BITS-1], r_mcand} : '0;
    assign sum    = r_hi + addend;
    assign n_hi   = {sum[MUL_A_BITS], sum[MUL_A_BITS:1]};
    assign n_lo   = {sum[0], r_lo[COEF_BITS-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= MUL_CNT_BITS'(COEF_BITS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == MUL_CNT_BITS'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
        end else if (r_cnt != '0) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo[COEF_BITS-1]};

endmodule

// ----- tb/tb_stereo_tremolo_lfo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_stereo_tremolo_lfo: self-checking bench for the stereo tremolo
// Drives stereo frames through the valid/stall input channel and compares
// every output transaction with a frame-accurate predictor of the LFO,
// smoother and gain stage. Covers corner samples, every shape code, pan sync
// on and off, out-of-range registers, a long output hold and random idling.
// ============================================================================
module tb_stereo_tremolo_lfo;
    import stl_pkg::*;

    localparam int CLK_HALF           = 5;
    localparam int RESET_CYCLES       = 8;
    localparam int QUIET_LIMIT        = 4000;  // frame + long hold, several times over
    localparam int DRAIN_PAD          = 8;
    localparam int TAIL_CYCLES        = 300;
    localparam int LONG_HOLD          = 800;
    localparam int LONG_HOLD_SETTING  = 10;
    localparam int RANDOM_SETTINGS    = 24;
    localparam int FRAMES_PER_SETTING = 47;
    localparam int CFG_INDEX_COUNT    = 5;
    localparam int SHAPE_CODES        = 8;
    localparam int MAX_REPORTS        = 30;
    localparam int TB_SINE_BITS       = 10;
    localparam int TB_QUARTER_BITS    = TB_SINE_BITS - 2;

    localparam logic [15:0] Q_FULL   = 16'd32768;
    localparam int          UNITY    = 32768;
    localparam logic [31:0] NOISE_TAPS  = 32'h8020_0003;
    localparam logic [31:0] PULSE_END   = 32'd858993459;
    localparam logic [31:0] HALF_CYCLE  = 32'h8000_0000;
    localparam logic [31:0] QUARTER_END = 32'h4000_0000;
    localparam logic [31:0] FALL_END    = 32'hC000_0000;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h80_0000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'hFF_FFFF;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // ------------------------------------------------------------------------
    // Tracker: keeps its own copy of the LFO state and registers, predicts
    // the modulated frame for every accepted input and checks the outputs.
    // ------------------------------------------------------------------------
    class tremolo_tracker;
        bit [31:0] phase_inc;
        bit [15:0] depth;
        bit [2:0]  shape;
        bit [15:0] coeff;
        bit        pan;
        bit [31:0] lfo_phase;
        bit [31:0] noise_reg;
        int        smooth_l;
        int        smooth_r;
        int        sine_rom [1 << TB_SINE_BITS];
        t_out_frame pending_frames [$];
        int        mismatches;
        int        frames_in;
        int        frames_out;

        function new();
            for (int i = 0; i < (1 << TB_SINE_BITS); i++) begin
                sine_rom[i] = sine_entry(i);
            end
            phase_inc  = 32'd402653;
            depth      = 16'd24576;
            shape      = WAVE_SINE;
            coeff      = 16'd23036;
            pan        = 1'b0;
            lfo_phase  = '0;
            noise_reg  = 32'hACE1_ACE1;
            smooth_l   = 0;
            smooth_r   = 0;
            mismatches = 0;
            frames_in  = 0;
            frames_out = 0;
        endfunction

        // Quarter-wave Taylor series, mirrored into four quadrants.
        function int sine_entry(int unsigned idx);
            int unsigned quad;
            int unsigned k;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned r;
            longint unsigned s;
            quad = (idx >> TB_QUARTER_BITS) & 3;
            k    = idx & ((1 << TB_QUARTER_BITS) - 1);
            if (quad[0]) begin
                k = (1 << TB_QUARTER_BITS) - k;
            end
            x  = (64'(k) * HALF_PI_Q30) >> TB_QUARTER_BITS;
            x2 = (x * x) >> 30;
            r  = ONE_Q30;
            r  = ONE_Q30 - ((x2 * r) >> 30) / 110;
            r  = ONE_Q30 - ((x2 * r) >> 30) / 72;
            r  = ONE_Q30 - ((x2 * r) >> 30) / 42;
            r  = ONE_Q30 - ((x2 * r) >> 30) / 20;
            r  = ONE_Q30 - ((x2 * r) >> 30) / 6;
            s  = (x * r) >> 30;
            s  = (s * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
            if (s > 64'd32768) begin
                s = 64'd32768;
            end
            return quad[1] ? -int'(s) : int'(s);
        endfunction

        // Sixteen Galois shifts, then take the top half as a signed draw.
        function int noise_draw();
            for (int i = 0; i < 16; i++) begin
                if (noise_reg[0]) begin
                    noise_reg = (noise_reg >> 1) ^ NOISE_TAPS;
                end else begin
                    noise_reg = noise_reg >> 1;
                end
            end
            return int'({16'd0, noise_reg[31:16]}) - UNITY;
        endfunction

        function int lfo_value(bit [31:0] p);
            int t;
            t = int'(p >> 15);
            case (shape)
                WAVE_SINE:     return sine_rom[p[31:32-TB_SINE_BITS]];
                WAVE_TRIANGLE: begin
                    if (p < QUARTER_END) return t;
                    if (p < FALL_END) return 65536 - t;
                    return t - 131072;
                end
                WAVE_SAW:      return int'({16'd0, p[31:16]}) - UNITY;
                WAVE_NOISE:    return noise_draw();
                WAVE_SQUARE:   return p[31] ? -UNITY : UNITY;
                WAVE_PULSE:    return (p <= PULSE_END) ? UNITY : -UNITY;
                default:       return 0;
            endcase
        endfunction

        // One-pole smoother followed by the depth mapping to a Q1.15 gain.
        function int smoothed_gain(int raw, inout int state);
            longint c;
            longint d;
            longint s;
            longint u;
            c = (coeff > Q_FULL) ? 64'sd32768 : longint'(coeff);
            d = (depth > Q_FULL) ? 64'sd32768 : longint'(depth);
            s = longint'(state) + (((longint'(raw) - longint'(state)) * c) >>> 15);
            state = int'(s);
            u = (s + 32768) >>> 1;
            return int'(64'sd32768 - ((u * d) >>> 15));
        endfunction

        function logic [SAMPLE_BITS-1:0] scaled(logic signed [SAMPLE_BITS-1:0] x, int gain);
            longint y;
            y = (longint'(x) * longint'(gain)) >>> 15;
            return y[SAMPLE_BITS-1:0];
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_PHASE_INC: phase_inc = data;
                CFG_DEPTH:     depth     = data[15:0];
                CFG_SHAPE:     shape     = data[2:0];
                CFG_SMOOTH:    coeff     = data[15:0];
                CFG_PAN_SYNC:  pan       = data[0];
                default: ;
            endcase
        endfunction

        function void note_frame_in(t_in_frame f);
            int gain_l;
            int gain_r;
            t_out_frame want;
            gain_l = smoothed_gain(lfo_value(lfo_phase), smooth_l);
            if (pan) begin
                gain_r = smoothed_gain(lfo_value(lfo_phase + HALF_CYCLE), smooth_r);
            end else begin
                gain_r = gain_l;
            end
            want.left_out  = scaled(f.left_in, gain_l);
            want.right_out = scaled(f.right_in, gain_r);
            pending_frames.push_back(want);
            lfo_phase = lfo_phase + phase_inc;
            frames_in++;
        endfunction

        task report_mismatch(string what, logic [SAMPLE_BITS-1:0] got,
                             logic [SAMPLE_BITS-1:0] want);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t mismatch in output frame %0d: %s got %h expected %h",
                         $time, frames_out, what, got, want);
            end
        endtask

        task check_frame_out(t_out_frame got);
            t_out_frame want;
            frames_out++;
            if (pending_frames.size() == 0) begin
                report_mismatch("frame with nothing pending, left", got.left_out, '0);
                return;
            end
            want = pending_frames.pop_front();
            if (got.left_out !== want.left_out) begin
                report_mismatch("left_out", got.left_out, want.left_out);
            end
            if (got.right_out !== want.right_out) begin
                report_mismatch("right_out", got.right_out, want.right_out);
            end
        endtask

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_frame                 i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_frame                o_out_data;

    tremolo_tracker tracker = new();

    bit hold_request = 1'b0;   // set by stimulus, cleared by the receiver
    int quiet_cycles = 0;
    int settings_used = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    stereo_tremolo_lfo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // Driver tasks: all inputs change at the falling edge.
    // ------------------------------------------------------------------------

    // Present one frame and hold it until the block takes it.
    task automatic send_frame(input t_in_frame f);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_frame_in(f);
    endtask

    // Drop valid for a gap set by n; scramble the idle payload.
    task automatic idle_gap(input int n);
        if (n == 0) return;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_in_data  <= t_in_frame'({$urandom, $urandom});
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_reg(index, data);
    endtask

    // Wait for every predicted frame to come back, then settle briefly.
    task automatic drain();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] corner_sample(input int k);
        case (k % 5)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return SAMPLE_NEG1;
            default: return 24'd1;
        endcase
    endfunction

    function automatic t_in_frame corner_frame(input int k);
        t_in_frame f;
        f.left_in  = corner_sample(k);
        f.right_in = corner_sample(k + 2);
        return f;
    endfunction

    // Mostly full-range noise, with the corners mixed in.
    function automatic t_in_frame random_frame();
        t_in_frame f;
        logic [31:0] r;
        r = $urandom;
        f.left_in  = ($urandom_range(0, 9) < 2) ? corner_sample($urandom_range(0, 4)) : r[23:0];
        r = $urandom;
        f.right_in = ($urandom_range(0, 9) < 2) ? corner_sample($urandom_range(0, 4)) : r[23:0];
        return f;
    endfunction

    // Fill the bits above a register's width with junk the block must drop.
    function automatic logic [31:0] pad_junk(input logic [31:0] value, input int width);
        logic [31:0] keep;
        keep = (32'd1 << width) - 32'd1;
        return ($urandom & ~keep) | (value & keep);
    endfunction

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return HALF_CYCLE;
            3, 4:    return $urandom_range(1, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return Q_FULL;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Program one full register setting; the first two are the extremes.
    task automatic program_setting(input int n);
        logic [31:0] inc_v;
        logic [15:0] depth_v;
        logic [15:0] coeff_v;
        logic        pan_v;
        if (n == 0) begin
            inc_v = '1;  depth_v = Q_FULL; coeff_v = Q_FULL;
        end else if (n == 1) begin
            inc_v = '0;  depth_v = '0;     coeff_v = '0;
        end else begin
            inc_v = pick_increment(); depth_v = pick_q15(); coeff_v = pick_q15();
        end
        pan_v = (n < SHAPE_CODES) ? 1'b0 : (n < 2 * SHAPE_CODES) ? 1'b1 : 1'($urandom);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_INDEX_BITS'($urandom_range(CFG_INDEX_COUNT,
                      (1 << CFG_INDEX_BITS) - 1)), $urandom);
        end
        write_reg(CFG_PHASE_INC, inc_v);
        write_reg(CFG_DEPTH, pad_junk(32'(depth_v), 16));
        write_reg(CFG_SHAPE, pad_junk(32'(n % SHAPE_CODES), 3));
        write_reg(CFG_SMOOTH, pad_junk(32'(coeff_v), 16));
        write_reg(CFG_PAN_SYNC, pad_junk(32'(pan_v), 1));
        settings_used++;
    endtask

    // Send a run of random frames in bursts with gaps up to max_gap.
    task automatic send_frames(input int count, input int max_gap);
        int burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (i != 0 && max_gap != 0) begin
                    idle_gap($urandom_range(0, max_gap));
                end
            end
            send_frame(random_frame());
            burst_left--;
        end
        drop_valid();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int gap_max;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner samples at the power-up register values.
        for (int k = 0; k < 4; k++) begin
            send_frame(corner_frame(k));
        end
        drop_valid();
        drain();
        settings_used++;

        // Big phase steps force wraps; depth and smoothing written above full
        // scale must saturate, and a write to an unused index must be dropped.
        write_reg(CFG_PHASE_INC, 32'h3000_0000);
        write_reg(CFG_DEPTH, 32'h0000_FFFF);
        write_reg(CFG_SMOOTH, 32'h0000_FFFF);
        write_reg(CFG_PAN_SYNC, 32'd1);
        write_reg(CFG_INDEX_BITS'(CFG_INDEX_COUNT), 32'hFFFF_FFFF);

        // Walk every shape code with pan sync on, the unused codes included.
        for (int s = 0; s < SHAPE_CODES; s++) begin
            write_reg(CFG_SHAPE, 32'(s));
            send_frame(corner_frame(2 * s));
            send_frame(corner_frame(2 * s + 1));
            drop_valid();
            drain();
            settings_used++;
        end

        // Pan sync off: right reuses the left gain, right smoother holds.
        write_reg(CFG_PAN_SYNC, 32'd0);
        write_reg(CFG_SHAPE, 32'(WAVE_NOISE));
        send_frame(corner_frame(1));
        send_frame(corner_frame(3));
        drop_valid();
        drain();
        settings_used++;

        // Random part: one register setting per run, drained in between.
        for (int n = 0; n < RANDOM_SETTINGS; n++) begin
            program_setting(n);
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 4;
                2:       gap_max = 30;
                default: gap_max = 12;
            endcase
            if (n == LONG_HOLD_SETTING) begin
                // Hold the output off while frames keep coming, so the block
                // backs up and stalls its input.
                hold_request = 1'b1;
                gap_max = 0;
            end
            send_frames(FRAMES_PER_SETTING, gap_max);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("coverage: %0d frames in, %0d out, over %0d register settings",
                 tracker.frames_in, tracker.frames_out, settings_used);
        $display("coverage: all shape codes, pan sync both ways, saturated and zero depth"
                 , " and smoothing, one long output hold; %0d mismatches", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, with a one-off long hold.
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_rx_mode mode;
        int       len;
        int       period;
        forever begin
            mode   = t_rx_mode'($urandom_range(0, 3));
            len    = $urandom_range(30, 400);
            period = $urandom_range(2, 9);
            for (int tick = 0; tick < len; tick++) begin
                @(negedge i_clk);
                if (hold_request) begin
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    hold_request = 1'b0;
                    i_out_stall <= 1'b0;
                end else begin
                    case (mode)
                        RX_FREE:  i_out_stall <= 1'b0;
                        RX_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 40);
                        RX_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 85);
                        default:  i_out_stall <= ((tick % period) < (period / 2));
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: check every accepted output transaction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            tracker.check_frame_out(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d frames pending",
                         quiet_cycles, tracker.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
